### design/flg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flg_pkg: shared types and constants for the triangle LFO flanger
// Register indexes, reset values, field widths and the sequencer states.
// ----------------------------------------------------------------------------
package flg_pkg;

    localparam int DEFAULT_DELAY_DEPTH = 16384;
    localparam int DEFAULT_SAMPLE_BITS = 16;

    localparam int HP_W    = 18;
    localparam int STEP_W  = 18;
    localparam int BASE_W  = 13;
    localparam int GAIN_W  = 16;
    localparam int PHASE_W = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam int FRAC_BITS = 16;
    localparam int DELAY_W   = 37;

    localparam logic [HP_W-1:0]    HALF_PERIOD_RST = HP_W'(120000);
    localparam logic [STEP_W-1:0]  DELAY_STEP_RST  = STEP_W'(26214);
    localparam logic [BASE_W-1:0]  BASE_DELAY_RST  = '0;
    localparam logic [GAIN_W-1:0]  DRY_GAIN_RST    = GAIN_W'(32768);
    localparam logic [PHASE_W-1:0] START_PHASE_RST = '0;

    localparam logic [FRAC_BITS:0] ONE_Q16 = (FRAC_BITS+1)'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_PERIOD = 3'd0,
        REG_DELAY_STEP  = 3'd1,
        REG_BASE_DELAY  = 3'd2,
        REG_DRY_GAIN    = 3'd3,
        REG_START_PHASE = 3'd4
    } flg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROD,
        ST_ADDR,
        ST_RD0,
        ST_RD1,
        ST_MAC1,
        ST_SUM
    } flg_state_t;

    typedef struct packed {
        logic               load;
        logic               advance;
        logic [PHASE_W-1:0] load_phase;
    } flg_lfo_ctrl_t;

endpackage

### design/flg_delay_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flg_delay_ram: circular delay line storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module flg_delay_ram
    import flg_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DELAY_DEPTH,
    parameter int WIDTH = DEFAULT_SAMPLE_BITS
) (
    input  logic                     aclk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/flg_lfo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flg_lfo: triangle LFO phase counter
// Holds the phase, derives the triangle value and wraps at twice half_period.
// ----------------------------------------------------------------------------
module flg_lfo
    import flg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [HP_W-1:0]     half_period,
    input  flg_lfo_ctrl_t       ctrl,
    output logic [HP_W-1:0]     tri_val
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W-1:0] period;
    logic [PHASE_W:0]   phase_inc;
    logic [PHASE_W-1:0] fall;

    assign period    = {half_period, 1'b0};
    assign phase_inc = {1'b0, phase_reg} + (PHASE_W+1)'(1);
    assign fall      = period - phase_reg;

    always_comb begin
        if (half_period == '0 || phase_reg >= period) begin
            tri_val = '0;
        end else if (phase_reg <= {1'b0, half_period}) begin
            tri_val = phase_reg[HP_W-1:0];
        end else begin
            tri_val = fall[HP_W-1:0];
        end
    end

    always_comb begin
        phase_next = phase_reg;
        if (ctrl.load) begin
            phase_next = ctrl.load_phase;
        end else if (ctrl.advance) begin
            if (half_period == '0 || phase_inc >= {1'b0, period}) begin
                phase_next = '0;
            end else begin
                phase_next = phase_inc[PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= START_PHASE_RST;
        end else begin
            phase_reg <= phase_next;
        end
    end

endmodule

### design/triangle_lfo_flanger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_lfo_flanger: flanger with a triangle LFO and interpolated delay
// Sequencer around a single-port-read delay memory and a small mixer.
// ----------------------------------------------------------------------------
// An accepted sample passes ST_PROD, ST_ADDR, ST_RD0, ST_RD1, ST_MAC1 and
// ST_SUM, which registers the result onto m_valid. A new sample is taken only
// in ST_IDLE, once the last is done: the sequencer reads the two delay taps
// one after the other through the single read port. Reset: configuration
// returns to defaults, and the delay memory is zeroed while s_ready stays low.
module triangle_lfo_flanger
    import flg_pkg::*;
#(
    parameter int DELAY_DEPTH = DEFAULT_DELAY_DEPTH,
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_in_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_out_sample,
    output logic                          m_saturated
);

    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int S     = SAMPLE_BITS;
    localparam int ACC_W = SAMPLE_BITS + 20;
    localparam logic [AW:0]        DEPTH_EXT = (AW+1)'(DELAY_DEPTH);
    localparam logic [AW-1:0]      LAST_ADDR = AW'(DELAY_DEPTH - 1);
    localparam logic [DELAY_W-1:0] DMAX      = DELAY_W'(DELAY_DEPTH - 1) << FRAC_BITS;

    // configuration
    logic [HP_W-1:0]   half_period_reg;
    logic [STEP_W-1:0] delay_step_reg;
    logic [BASE_W-1:0] base_delay_reg;
    logic [GAIN_W-1:0] dry_gain_reg;
    logic              cfg_accept;

    // control
    flg_state_t        state_reg, state_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;

    // datapath
    logic signed [S-1:0]    x_reg;
    logic [HP_W-1:0]        tri_reg;
    logic [35:0]            prod_reg;
    logic signed [S+16:0]   dry_reg;
    logic [AW-1:0]          dint_reg;
    logic [FRAC_BITS-1:0]   frac_reg;
    logic [AW-1:0]          idx0_reg;
    logic signed [S+17:0]   p0_reg;
    logic signed [S+17:0]   p1_reg;
    logic signed [S-1:0]    out_sample_reg;
    logic                   sat_reg;

    logic                   accept;
    logic                   load_out;
    logic [HP_W-1:0]        tri_val;
    flg_lfo_ctrl_t          lfo_ctrl;
    logic                   mem_wen;
    logic [AW-1:0]          mem_waddr;
    logic [S-1:0]           mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [S-1:0]           mem_rdata;

    logic [35:0]            prod_c;
    logic signed [S+16:0]   dry_c;
    logic [DELAY_W-1:0]     d_c, d_sat;
    logic [AW:0]            diff_c, idx0_wide;
    logic [AW-1:0]          idx0_c, idx1_c;
    logic [FRAC_BITS:0]     w0_c;
    logic signed [S+17:0]   p0_c, p1_c;
    logic signed [ACC_W-1:0] acc_c;
    logic signed [S+3:0]    y_c;
    logic                   sat_c;
    logic signed [S-1:0]    out_c;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign accept     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RST;
            delay_step_reg  <= DELAY_STEP_RST;
            base_delay_reg  <= BASE_DELAY_RST;
            dry_gain_reg    <= DRY_GAIN_RST;
        end else if (cfg_accept) begin
            unique case (flg_reg_t'(cfg_index))
                REG_HALF_PERIOD: half_period_reg <= cfg_data[HP_W-1:0];
                REG_DELAY_STEP:  delay_step_reg  <= cfg_data[STEP_W-1:0];
                REG_BASE_DELAY:  base_delay_reg  <= cfg_data[BASE_W-1:0];
                REG_DRY_GAIN:    dry_gain_reg    <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    flg_lfo u_lfo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .half_period (half_period_reg),
        .ctrl        (lfo_ctrl),
        .tri_val     (tri_val)
    );

    flg_delay_ram #(
        .DEPTH (DELAY_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_ram (
        .aclk  (aclk),
        .wen   (mem_wen),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Arithmetic for each sequencer step.
    assign prod_c = tri_reg * delay_step_reg;
    assign dry_c  = x_reg * $signed({1'b0, dry_gain_reg});

    assign d_c   = DELAY_W'({base_delay_reg, {FRAC_BITS{1'b0}}}) + DELAY_W'(prod_reg);
    assign d_sat = (d_c > DMAX) ? DMAX : d_c;

    // The tap D samples back, wrapped into the circular memory.
    assign diff_c    = {1'b0, wp_reg} - {1'b0, dint_reg};
    assign idx0_wide = diff_c[AW] ? (diff_c + DEPTH_EXT) : diff_c;
    assign idx0_c    = idx0_wide[AW-1:0];
    assign idx1_c    = (idx0_reg == '0) ? LAST_ADDR : (idx0_reg - AW'(1));

    assign w0_c = ONE_Q16 - {1'b0, frac_reg};
    assign p0_c = $signed(mem_rdata) * $signed({1'b0, w0_c});
    assign p1_c = $signed(mem_rdata) * $signed({2'b00, frac_reg});

    assign acc_c = (ACC_W'(dry_reg) <<< 1) + ACC_W'(p0_reg) + ACC_W'(p1_reg)
                 + ACC_W'(32768);
    assign y_c   = acc_c[ACC_W-1:FRAC_BITS];
    assign sat_c = !((&y_c[S+3:S-1]) || !(|y_c[S+3:S-1]));
    always_comb begin
        if (!sat_c) begin
            out_c = y_c[S-1:0];
        end else if (y_c[S+3]) begin
            out_c = {1'b1, {(S-1){1'b0}}};
        end else begin
            out_c = {1'b0, {(S-1){1'b1}}};
        end
    end

    // Sequencer
    always_comb begin
        state_next         = state_reg;
        wp_next            = wp_reg;
        clr_next           = clr_reg;
        out_valid_next     = out_valid_reg;
        s_ready            = 1'b0;
        load_out           = 1'b0;
        mem_wen            = 1'b0;
        mem_waddr          = wp_reg;
        mem_wdata          = s_in_sample;
        mem_raddr          = idx0_c;
        lfo_ctrl.load       = cfg_accept && (flg_reg_t'(cfg_index) == REG_START_PHASE);
        lfo_ctrl.advance    = 1'b0;
        lfo_ctrl.load_phase = cfg_data[PHASE_W-1:0];

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_wen   = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // s_ready is high throughout this state, so s_valid alone
                // marks the accepted transaction.
                s_ready = 1'b1;
                mem_wen = s_valid;
                if (s_valid) begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD: state_next = ST_ADDR;
            ST_ADDR: state_next = ST_RD0;
            ST_RD0: begin
                mem_raddr  = idx0_c;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                mem_raddr  = idx1_c;
                state_next = ST_MAC1;
            end
            ST_MAC1: state_next = ST_SUM;
            ST_SUM: begin
                if (!out_valid_reg || m_ready) begin
                    load_out         = 1'b1;
                    out_valid_next   = 1'b1;
                    lfo_ctrl.advance = 1'b1;
                    wp_next          = (wp_reg == LAST_ADDR) ? '0 : (wp_reg + AW'(1));
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            wp_reg        <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg   <= s_in_sample;
            tri_reg <= tri_val;
        end
        if (state_reg == ST_PROD) begin
            prod_reg <= prod_c;
            dry_reg  <= dry_c;
        end
        if (state_reg == ST_ADDR) begin
            dint_reg <= d_sat[FRAC_BITS +: AW];
            frac_reg <= d_sat[FRAC_BITS-1:0];
        end
        if (state_reg == ST_RD0) begin
            idx0_reg <= idx0_c;
        end
        if (state_reg == ST_RD1) begin
            p0_reg <= p0_c;
        end
        if (state_reg == ST_MAC1) begin
            p1_reg <= p1_c;
        end
        if (load_out) begin
            out_sample_reg <= out_c;
            sat_reg        <= sat_c;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_sample = out_sample_reg;
    assign m_saturated  = sat_reg;

    // An accepted transaction always starts the multiply step.
    a_accept_to_prod: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_PROD))
        else $error("accepted sample did not enter the multiply step");

    // A new result only ever comes out of the final mixing step.
    a_result_from_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $rose(out_valid_reg)) |-> $past(state_reg == ST_SUM))
        else $error("result raised outside the mixing step");

    // The write pointer moves only when a result is handed to the output.
    a_wp_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (wp_reg != $past(wp_reg))) |-> $past(load_out))
        else $error("write pointer moved without a finished sample");

    // A finished sample waits while the previous result is still held.
    a_sum_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM && out_valid_reg && !m_ready)
            |=> (state_reg == ST_SUM && out_valid_reg))
        else $error("result overwritten while the output was stalled");

endmodule
